// ----- src/avcd_pkg.sv -----
// avcd_pkg: shared types, constants and helpers for the start-code codec probe
package avcd_pkg;

  localparam int POS_BITS     = 24;
  localparam int OUT_POS_BITS = 24;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [1:0] CODEC_NONE = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;
  localparam logic [1:0] CODEC_AVC  = 2'd2;
  localparam logic [1:0] CODEC_MPEG = 2'd3;

  localparam logic [7:0] MPEG_SEQ_HDR  = 8'hB3;
  localparam logic [7:0] MPEG_EXT      = 8'hB5;
  localparam logic [7:0] MPEG_GOP      = 8'hB8;
  localparam logic [4:0] AVC_SPS       = 5'd7;
  localparam logic [4:0] AVC_PPS       = 5'd8;
  localparam logic [4:0] AVC_IDR       = 5'd5;
  localparam logic [5:0] HEVC_VPS      = 6'd32;
  localparam logic [5:0] HEVC_PPS      = 6'd34;
  localparam logic [5:0] HEVC_IDR_W    = 6'd19;
  localparam logic [5:0] HEVC_CRA      = 6'd21;
  localparam logic [POS_BITS-1:0] MIN_LAST_POS = POS_BITS'(5);

  typedef struct packed {
    logic [3:0]          hevc_mask;
    logic [2:0]          avc_mask;
    logic [2:0]          mpeg_mask;
    logic [POS_BITS-1:0] hevc_position;
    logic [POS_BITS-1:0] avc_position;
    logic [POS_BITS-1:0] mpeg_position;
    logic [POS_BITS-1:0] pos;
  } evidence_t;

  function automatic logic [2:0] count4(input logic [3:0] m);
    count4 = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
  endfunction

endpackage

// ----- src/avcd_scan.sv -----
// avcd_scan: start-code tracking and per-codec evidence state
module avcd_scan import avcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic [7:0] data_byte,
  input  logic      is_last,
  output evidence_t evid
);

  logic [1:0]          zero_run, zero_run_next;
  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic                header_next, header_next_next;
  logic [POS_BITS-1:0] pending_start, pending_start_next;
  logic                hevc_pending, hevc_pending_next;
  logic [7:0]          hevc_first_header, hevc_first_header_next;
  logic [3:0]          hevc_mask, hevc_mask_next;
  logic [2:0]          avc_mask, avc_mask_next;
  logic [2:0]          mpeg_mask, mpeg_mask_next;
  logic [POS_BITS-1:0] hevc_position, hevc_position_next;
  logic [POS_BITS-1:0] avc_position, avc_position_next;
  logic [POS_BITS-1:0] mpeg_position, mpeg_position_next;
  logic                scan_done, scan_done_next;

  logic [5:0]          kind;
  logic [3:0]          hevc_bit;
  logic [2:0]          mpeg_bit;
  logic [2:0]          avc_bit;
  logic [POS_BITS-1:0] back;

  always_comb begin
    zero_run_next          = zero_run;
    header_next_next       = header_next;
    pending_start_next     = pending_start;
    hevc_pending_next      = hevc_pending;
    hevc_first_header_next = hevc_first_header;
    hevc_mask_next         = hevc_mask;
    avc_mask_next          = avc_mask;
    mpeg_mask_next         = mpeg_mask;
    hevc_position_next     = hevc_position;
    avc_position_next      = avc_position;
    mpeg_position_next     = mpeg_position;
    scan_done_next         = scan_done;
    kind     = hevc_first_header[6:1];
    hevc_bit = 4'd0;
    mpeg_bit = 3'd0;
    avc_bit  = 3'd0;
    back     = (zero_run == 2'd3) ? POS_BITS'(3) : POS_BITS'(2);

    if (!scan_done) begin
      // second header byte of an hevc unit
      if (hevc_pending) begin
        hevc_pending_next = 1'b0;
        if (data_byte[2:0] != 3'd0 && !hevc_first_header[0] && data_byte[7:3] == 5'd0) begin
          if (kind >= HEVC_VPS && kind <= HEVC_PPS) begin
            hevc_bit = 4'(1) << (kind - HEVC_VPS);
          end else if (kind >= HEVC_IDR_W && kind <= HEVC_CRA && hevc_mask[2:0] != 3'd0) begin
            hevc_bit = 4'b1000;
          end
          if (hevc_bit != 4'd0) begin
            hevc_mask_next     = hevc_mask | hevc_bit;
            hevc_position_next = pending_start;
          end
        end
      end
      // first header byte after a start code
      if (header_next) begin
        header_next_next = 1'b0;
        if (data_byte == MPEG_SEQ_HDR) mpeg_bit = 3'b001;
        else if (data_byte == MPEG_EXT) mpeg_bit = 3'b010;
        else if (data_byte == MPEG_GOP) mpeg_bit = 3'b100;
        if (mpeg_bit != 3'd0) begin
          mpeg_mask_next     = mpeg_mask | mpeg_bit;
          mpeg_position_next = pending_start;
          if (mpeg_mask_next[0] && mpeg_mask_next[2:1] != 2'd0) begin
            scan_done_next = 1'b1;
          end
        end
        if (!scan_done_next && !data_byte[7]) begin
          hevc_pending_next      = 1'b1;
          hevc_first_header_next = data_byte;
          if (data_byte[6:5] != 2'd0) begin
            if (data_byte[4:0] == AVC_SPS) avc_bit = 3'b001;
            else if (data_byte[4:0] == AVC_PPS) avc_bit = 3'b010;
            else if (data_byte[4:0] == AVC_IDR) avc_bit = 3'b100;
            if (avc_bit != 3'd0) begin
              avc_mask_next     = avc_mask | avc_bit;
              avc_position_next = pending_start;
            end
          end
        end
      end
      // zero run and start code search
      if (!scan_done_next) begin
        if (data_byte == 8'd0) begin
          if (zero_run != 2'd3) zero_run_next = zero_run + 2'd1;
        end else begin
          if (data_byte == 8'd1 && zero_run >= 2'd2) begin
            pending_start_next = (byte_position >= back) ? byte_position - back : '0;
            header_next_next   = 1'b1;
          end
          zero_run_next = 2'd0;
        end
      end
    end
    byte_position_next = (byte_position != POS_MAX) ? byte_position + POS_BITS'(1)
                                                     : byte_position;
  end

  always_comb begin
    evid.hevc_mask     = hevc_mask_next;
    evid.avc_mask      = avc_mask_next;
    evid.mpeg_mask     = mpeg_mask_next;
    evid.hevc_position = hevc_position_next;
    evid.avc_position  = avc_position_next;
    evid.mpeg_position = mpeg_position_next;
    evid.pos           = byte_position;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      zero_run          <= 2'd0;
      byte_position     <= '0;
      header_next       <= 1'b0;
      pending_start     <= '0;
      hevc_pending      <= 1'b0;
      hevc_first_header <= 8'd0;
      hevc_mask         <= 4'd0;
      avc_mask          <= 3'd0;
      mpeg_mask         <= 3'd0;
      hevc_position     <= '0;
      avc_position      <= '0;
      mpeg_position     <= '0;
      scan_done         <= 1'b0;
    end else if (step) begin
      zero_run          <= zero_run_next;
      byte_position     <= byte_position_next;
      header_next       <= header_next_next;
      pending_start     <= pending_start_next;
      hevc_pending      <= hevc_pending_next;
      hevc_first_header <= hevc_first_header_next;
      hevc_mask         <= hevc_mask_next;
      avc_mask          <= avc_mask_next;
      mpeg_mask         <= mpeg_mask_next;
      hevc_position     <= hevc_position_next;
      avc_position      <= avc_position_next;
      mpeg_position     <= mpeg_position_next;
      scan_done         <= scan_done_next;
    end
  end

endmodule

// ----- src/avcd_verdict.sv -----
// avcd_verdict: picks the winning codec from the evidence masks
module avcd_verdict import avcd_pkg::*; (
  input  evidence_t           evid,
  output logic [1:0]          codec,
  output logic [2:0]          distinct_types,
  output logic [POS_BITS-1:0] winner_position
);

  logic       mok, hok, aok;
  logic [2:0] hh, hp, ah, mh;

  always_comb begin
    mok = evid.mpeg_mask[0] && evid.mpeg_mask[2:1] != 2'd0;
    hh  = count4(evid.hevc_mask);
    hp  = count4({1'b0, evid.hevc_mask[2:0]});
    ah  = count4({1'b0, evid.avc_mask});
    mh  = count4({1'b0, evid.mpeg_mask});
    hok = hh >= 3'd2 && (evid.hevc_mask[0] || hp >= 3'd2) && !mok;
    aok = ah >= 3'd2 && !mok;

    codec           = CODEC_NONE;
    distinct_types  = 3'd0;
    winner_position = '0;
    if (evid.pos >= MIN_LAST_POS) begin
      if (hok) begin
        codec           = CODEC_HEVC;
        distinct_types  = hh;
        winner_position = evid.hevc_position;
      end
      if (aok && (codec == CODEC_NONE || ah > distinct_types ||
                  (ah == distinct_types && evid.avc_position > winner_position))) begin
        codec           = CODEC_AVC;
        distinct_types  = ah;
        winner_position = evid.avc_position;
      end
      if (mok && (codec == CODEC_NONE || mh > distinct_types ||
                  (mh == distinct_types && evid.mpeg_position > winner_position))) begin
        codec           = CODEC_MPEG;
        distinct_types  = mh;
        winner_position = evid.mpeg_position;
      end
    end
  end

endmodule

// ----- src/annexb_video_codec_detect_core.sv -----
// annexb_video_codec_detect_core: top level of the annex-b start-code codec probe
//
//  channel   handshake                     payload
//  bytes     byte_valid / byte_stall       data_byte, is_last
//  verdict   verdict_valid / verdict_stall codec, distinct_types, winner_position
//
// one byte per cycle while no last byte waits: a transfer lands in the input register,
// a step then scans it and updates the evidence state, and a last byte's step
// also loads the verdict register, which drives verdict_valid and the payload.
// only a last byte can wait, while a previous verdict is held by verdict_stall.
// rst is synchronous and clears all control and evidence state; after each
// verdict the scan state returns to reset for the next buffer.
module annexb_video_codec_detect_core import avcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  logic [7:0]              data_byte,
  input  logic                    is_last,
  output logic                    verdict_valid,
  input  logic                    verdict_stall,
  output logic [1:0]              codec,
  output logic [2:0]              distinct_types,
  output logic [OUT_POS_BITS-1:0] winner_position
);

  logic                in_full;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                step;
  evidence_t           evid;
  logic [1:0]          v_codec;
  logic [2:0]          v_types;
  logic [POS_BITS-1:0] v_pos;

  assign step       = in_full && (!in_last || !verdict_valid || !verdict_stall);
  assign byte_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= data_byte;
      in_last <= is_last;
    end
  end

  avcd_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .is_last   (in_last),
    .evid      (evid)
  );

  avcd_verdict u_verdict (
    .evid            (evid),
    .codec           (v_codec),
    .distinct_types  (v_types),
    .winner_position (v_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (step && in_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      codec           <= v_codec;
      distinct_types  <= v_types;
      winner_position <= OUT_POS_BITS'(v_pos);
    end
  end

endmodule

// ----- sim/tb_annexb_video_codec_detect_core.sv -----
// testbench for annexb_video_codec_detect_core: directed and random byte buffers checked against a scan model
`timescale 1ns / 1ps

module tb_annexb_video_codec_detect_core import avcd_pkg::*;;

  localparam int STALL_LIMIT = 5000;
  localparam int BYTE_TARGET = 1550;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              hits;
    logic [OUT_POS_BITS-1:0] position;
  } verdict_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    byte_valid = 1'b0;
  logic                    byte_stall;
  logic [7:0]              data_byte = 8'h00;
  logic                    is_last = 1'b0;
  logic                    verdict_valid;
  logic                    verdict_stall = 1'b0;
  logic [1:0]              codec;
  logic [2:0]              distinct_types;
  logic [OUT_POS_BITS-1:0] winner_position;

  byte_item_t byte_q[$];
  verdict_t   verdict_q[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         bytes_sent = 0;
  int         bytes_total = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  bit         byte_taken = 1'b0;

  // scan state
  logic [1:0]          zrun;
  logic [POS_BITS-1:0] bpos;
  bit                  hdr_next;
  logic [POS_BITS-1:0] pstart;
  bit                  hv_pend;
  logic [7:0]          hv_h0;
  logic [3:0]          hv_mask;
  logic [2:0]          avc_mask;
  logic [2:0]          mpg_mask;
  logic [POS_BITS-1:0] hv_pos;
  logic [POS_BITS-1:0] avc_pos;
  logic [POS_BITS-1:0] mpg_pos;
  bit                  scan_done;

  annexb_video_codec_detect_core u_top (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .is_last         (is_last),
    .verdict_valid   (verdict_valid),
    .verdict_stall   (verdict_stall),
    .codec           (codec),
    .distinct_types  (distinct_types),
    .winner_position (winner_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_scan();
    zrun      = '0;
    bpos      = '0;
    hdr_next  = 1'b0;
    pstart    = '0;
    hv_pend   = 1'b0;
    hv_h0     = '0;
    hv_mask   = '0;
    avc_mask  = '0;
    mpg_mask  = '0;
    hv_pos    = '0;
    avc_pos   = '0;
    mpg_pos   = '0;
    scan_done = 1'b0;
  endtask

  task automatic hevc_unit(input logic [7:0] h0, input logic [7:0] h1,
                           input logic [POS_BITS-1:0] start);
    logic [5:0] kind;
    logic [3:0] hit;
    kind = h0[6:1];
    hit  = '0;
    if (h1[2:0] != 3'd0 && !h0[0] && h1[7:3] == 5'd0) begin
      if (kind >= HEVC_VPS && kind <= HEVC_PPS)
        hit = 4'b0001 << (kind - HEVC_VPS);
      else if (kind >= HEVC_IDR_W && kind <= HEVC_CRA && hv_mask[2:0] != 3'd0)
        hit = 4'b1000;
      if (hit != 4'd0) begin
        hv_mask |= hit;
        hv_pos = start;
      end
    end
  endtask

  task automatic header_unit(input logic [7:0] h0, input logic [POS_BITS-1:0] start);
    logic [2:0] hit;
    if (h0 == MPEG_SEQ_HDR || h0 == MPEG_EXT || h0 == MPEG_GOP) begin
      mpg_mask |= (h0 == MPEG_SEQ_HDR) ? 3'b001 : (h0 == MPEG_EXT) ? 3'b010 : 3'b100;
      mpg_pos = start;
      if (mpg_mask[0] && mpg_mask[2:1] != 2'd0)
        scan_done = 1'b1;
    end
    if (!scan_done && !h0[7]) begin
      hv_pend = 1'b1;
      hv_h0   = h0;
      if (h0[6:5] != 2'd0) begin
        case (h0[4:0])
          AVC_SPS: hit = 3'b001;
          AVC_PPS: hit = 3'b010;
          AVC_IDR: hit = 3'b100;
          default: hit = 3'b000;
        endcase
        if (hit != 3'd0) begin
          avc_mask |= hit;
          avc_pos = start;
        end
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] back;
    verdict_t            v;
    bit                  mok;
    bit                  hok;
    bit                  aok;
    int                  hh;
    int                  hp;
    int                  ah;
    int                  mh;
    pos = bpos;
    if (!scan_done) begin
      if (hv_pend) begin
        hv_pend = 1'b0;
        hevc_unit(hv_h0, b, pstart);
      end
      if (hdr_next) begin
        hdr_next = 1'b0;
        header_unit(b, pstart);
      end
      if (!scan_done) begin
        if (b == 8'h00) begin
          if (zrun < 2'd3) zrun++;
        end else begin
          if (b == 8'h01 && zrun >= 2'd2) begin
            back     = (zrun == 2'd3) ? POS_BITS'(3) : POS_BITS'(2);
            pstart   = (pos >= back) ? pos - back : '0;
            hdr_next = 1'b1;
          end
          zrun = '0;
        end
      end
    end
    if (bpos != POS_MAX) bpos++;
    if (last) begin
      v   = '0;
      mok = mpg_mask[0] && mpg_mask[2:1] != 2'd0;
      hh  = $countones(hv_mask);
      hp  = $countones(hv_mask[2:0]);
      ah  = $countones(avc_mask);
      mh  = $countones(mpg_mask);
      hok = hh >= 2 && (hv_mask[0] || hp >= 2) && !mok;
      aok = ah >= 2 && !mok;
      if (pos >= MIN_LAST_POS) begin
        if (hok) begin
          v.kind = CODEC_HEVC;
          v.hits = 3'(hh);
          v.position = OUT_POS_BITS'(hv_pos);
        end
        if (aok && (v.kind == CODEC_NONE || ah > v.hits ||
                    (ah == v.hits && OUT_POS_BITS'(avc_pos) > v.position))) begin
          v.kind = CODEC_AVC;
          v.hits = 3'(ah);
          v.position = OUT_POS_BITS'(avc_pos);
        end
        if (mok && (v.kind == CODEC_NONE || mh > v.hits ||
                    (mh == v.hits && OUT_POS_BITS'(mpg_pos) > v.position))) begin
          v.kind = CODEC_MPEG;
          v.hits = 3'(mh);
          v.position = OUT_POS_BITS'(mpg_pos);
        end
      end
      verdict_q.insert(verdict_q.size(), v);
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    byte_item_t it;
    it.data = b;
    it.last = last;
    byte_q.insert(byte_q.size(), it);
  endtask

  task automatic add_packed(input logic [79:0] v, input int n);
    int i;
    for (i = 0; i < n; i++)
      add_byte(v[8*(n-1-i) +: 8], i == n - 1);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_header();
    case ($urandom_range(0, 21))
      0:       return MPEG_SEQ_HDR;
      1:       return MPEG_EXT;
      2:       return MPEG_GOP;
      3:       return {1'b0, HEVC_VPS, 1'b0};
      4:       return {1'b0, HEVC_VPS + 6'd1, 1'b0};
      5:       return {1'b0, HEVC_PPS, 1'b0};
      6:       return {1'b0, HEVC_IDR_W, 1'b0};
      7:       return 8'h28;
      8:       return {1'b0, HEVC_CRA, 1'b0};
      9:       return {1'b0, HEVC_VPS, 1'b1};
      10:      return {3'b011, AVC_SPS};
      11:      return {3'b011, AVC_PPS};
      12:      return {3'b011, AVC_IDR};
      13:      return {3'b001, AVC_SPS};
      14:      return {3'b010, AVC_PPS};
      15:      return {3'b000, AVC_SPS};
      16:      return {3'b000, AVC_IDR};
      17:      return {3'b111, AVC_SPS};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_random_buffer();
    logic [7:0] bytes_q[$];
    int         zeros;
    int         r;
    int         cut;
    int         i;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) bytes_q.insert(bytes_q.size(), noise_byte());
    end else begin
      repeat ($urandom_range(1, 5)) begin
        r = $urandom_range(0, 19);
        if (r == 0) zeros = 1;
        else if (r < 4) zeros = $urandom_range(4, 6);
        else if (r < 11) zeros = 3;
        else zeros = 2;
        repeat (zeros) bytes_q.insert(bytes_q.size(), 8'h00);
        bytes_q.insert(bytes_q.size(),
                       ($urandom_range(0, 19) == 0) ? noise_byte() : 8'h01);
        bytes_q.insert(bytes_q.size(), pick_header());
        bytes_q.insert(bytes_q.size(),
                       ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 7))
                                                  : 8'($urandom));
        repeat ($urandom_range(0, 4)) bytes_q.insert(bytes_q.size(), noise_byte());
      end
    end
    if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, bytes_q.size());
    else cut = bytes_q.size();
    for (i = 0; i < cut; i++)
      add_byte(bytes_q[i], i == cut - 1);
  endtask

  always @(negedge clk) begin
    byte_item_t it;
    if (bytes_sent < bytes_total / 3) begin
      send_idle = 11;
      recv_idle = 66;
    end else if (bytes_sent < 2 * bytes_total / 3) begin
      send_idle = 66;
      recv_idle = 11;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        it = byte_q.pop_front();
        byte_valid <= 1'b1;
        data_byte  <= it.data;
        is_last    <= it.last;
        bytes_sent++;
      end else begin
        byte_valid <= 1'b0;
      end
    end
    verdict_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    verdict_t want;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      byte_taken = byte_valid && !byte_stall;
      if (byte_taken) begin
        scan_byte(data_byte, is_last);
        moved = 1'b1;
      end
      if (verdict_valid && !verdict_stall) begin
        moved = 1'b1;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending, codec", codec, 0);
        end else begin
          want = verdict_q.pop_front();
          if (codec != want.kind)
            report_mismatch("codec", codec, want.kind);
          if (distinct_types != want.hits)
            report_mismatch("distinct_types", distinct_types, want.hits);
          if (winner_position != want.position)
            report_mismatch("winner_position", winner_position, want.position);
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_scan();
    // short buffer with a header
    add_packed(80'h000001B3, 4);
    // two three-byte start codes with avc sps and pps headers, ending on a zero byte
    add_packed(80'h00000001670000016800, 9);
    // vps then sps
    add_packed(80'h00000140010000014201, 10);
    while (byte_q.size() < BYTE_TARGET) add_random_buffer();
    bytes_total = byte_q.size();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (byte_q.size() == 0 && !byte_valid);
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- annexb_video_codec_detect_core.f -----
src/avcd_pkg.sv
src/avcd_scan.sv
src/avcd_verdict.sv
src/annexb_video_codec_detect_core.sv
sim/tb_annexb_video_codec_detect_core.sv
